// ----- design/assert_macros.svh -----
// Assertion macros shared by the cursor sequence buffer RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define CSB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/csb_pkg.sv -----
// Package for the cursor sequence buffer: opcodes, status codes, field widths
// and the result struct passed from the sequencer to the top level.
`default_nettype none

package csb_pkg;

    localparam int OPCODE_W     = 3;
    localparam int WORD_W       = 64;
    localparam int STATUS_W     = 2;
    localparam int ITEM_COUNT_W = 7;

    localparam logic [OPCODE_W-1:0] OP_START   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADVANCE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ATTACH  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CURRENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    has_current;
        logic [ITEM_COUNT_W-1:0] item_count;
    } csb_res_t;

endpackage

`default_nettype wire

// ----- design/cursor_sequence_buffer_core.sv -----
// Cursor sequence buffer, top level: sequencer, word RAM and output register.
// Uses csb_pkg, csb_ctrl and csb_ram.
//
// Ordered store of up to CAPACITY 64-bit words with a cursor. One operation is
// taken at a time; in_ready is low while it runs. Start, advance, no-ops and
// refused operations go straight to fetch and done. Insert and attach run the
// shift loop, put the new word, then fetch and done; remove runs the shift loop,
// then fetch and done. The loop moves one word at a time, a read state then a
// write state, through the one read and one write port of the word RAM. A result
// waits in the output register while the next operation is already accepted.
`default_nettype none

module cursor_sequence_buffer_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [csb_pkg::OPCODE_W-1:0]      opcode,
    input  wire logic [csb_pkg::WORD_W-1:0]        entry_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [csb_pkg::STATUS_W-1:0]      status,
    output logic                                   has_current,
    output logic      [csb_pkg::WORD_W-1:0]        current_value,
    output logic      [csb_pkg::ITEM_COUNT_W-1:0]  item_count
);

    import csb_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_take;
    csb_res_t          res;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic                    has_current_reg;
    logic [WORD_W-1:0]       current_value_reg;
    logic [ITEM_COUNT_W-1:0] item_count_reg;
    logic                    load;

    csb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .entry_value (entry_value),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    csb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_take = !out_valid_reg || out_ready;
    assign load     = res_valid && res_take;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg        <= res.status;
            has_current_reg   <= res.has_current;
            current_value_reg <= res.has_current ? ram_rdata : '0;
            item_count_reg    <= res.item_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign has_current   = has_current_reg;
    assign current_value = current_value_reg;
    assign item_count    = item_count_reg;

endmodule

`default_nettype wire

// ----- design/csb_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module csb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/csb_ctrl.sv -----
// Sequencer of the cursor sequence buffer: count, cursor and the shift loop
// that moves words one at a time through the RAM. Uses csb_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module csb_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [csb_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [csb_pkg::WORD_W-1:0]    entry_value,
    output logic                               ram_we,
    output logic [$clog2(CAPACITY)-1:0]        ram_waddr,
    output logic [csb_pkg::WORD_W-1:0]         ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(CAPACITY)-1:0]        ram_raddr,
    input  wire logic [csb_pkg::WORD_W-1:0]    ram_rdata,
    output logic                               res_valid,
    input  wire logic                          res_take,
    output csb_pkg::csb_res_t                  res
);

    import csb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOOP  = 6'b000010,
        S_WR    = 6'b000100,
        S_PUT   = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                grow_reg, grow_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic          cur_valid;
    logic          full;
    logic          more;
    logic [CW-1:0] src;

    assign cur_valid = cursor_reg < count_reg;
    assign full      = count_reg >= CAP;
    assign more      = grow_reg ? (idx_reg > cursor_reg) : ((idx_reg + ONE) < count_reg);
    assign src       = grow_reg ? (idx_reg - ONE) : (idx_reg + ONE);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.has_current = cur_valid;
        res.item_count  = ITEM_COUNT_W'(count_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        grow_next   = grow_reg;
        word_next   = word_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = src[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_DONE;
                    word_next   = entry_value;
                    state_next  = S_FETCH;
                    unique case (opcode)
                        OP_START:
                        begin
                            cursor_next = '0;
                        end
                        OP_ADVANCE:
                        begin
                            if (cur_valid)
                            begin
                                cursor_next = cursor_reg + ONE;
                            end
                            else
                            begin
                                status_next = ST_NO_CURRENT;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                grow_next   = 1'b1;
                                cursor_next = cur_valid ? cursor_reg : '0;
                                idx_next    = count_reg;
                                state_next  = S_LOOP;
                            end
                        end
                        OP_ATTACH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                grow_next   = 1'b1;
                                cursor_next = cur_valid ? (cursor_reg + ONE) : count_reg;
                                idx_next    = count_reg;
                                state_next  = S_LOOP;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!cur_valid)
                            begin
                                status_next = ST_NO_CURRENT;
                            end
                            else
                            begin
                                grow_next  = 1'b0;
                                idx_next   = cursor_reg;
                                state_next = S_LOOP;
                            end
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_LOOP:
            begin
                if (more)
                begin
                    ram_re     = 1'b1;
                    state_next = S_WR;
                end
                else if (grow_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    count_next = count_reg - ONE;
                    state_next = S_FETCH;
                end
            end
            S_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = src;
                state_next = S_LOOP;
            end
            S_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cursor_reg[AW-1:0];
                ram_wdata  = word_reg;
                count_next = count_reg + ONE;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ram_re     = 1'b1;
                ram_raddr  = cursor_reg[AW-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            grow_reg   <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            grow_reg   <= grow_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    `CSB_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CAP, "item count above capacity")
    `CSB_ASSERT_NOW(a_cursor_le_count, state_reg == S_IDLE, cursor_reg <= count_reg,
        "cursor beyond item count")
    `CSB_ASSERT_NOW(a_count_step, count_reg != $past(count_reg),
        (count_reg == $past(count_reg) + ONE) || (count_reg == $past(count_reg) - ONE),
        "item count moved by more than one")
    `CSB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "word taken while sequencer busy")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for cursor_sequence_buffer_core: directed and random operations on
// the cursor store, each result checked against a behavioural copy of the store.
// Depends on csb_pkg and the cursor_sequence_buffer_core RTL.
`default_nettype none

module tb_top;

    import csb_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = 2 * CAPACITY + 16;

    // opcodes with no operation behind them
    localparam logic [OPCODE_W-1:0] OP_RSVD_0 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD_1 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_2 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic                    has_current;
        logic [WORD_W-1:0]       current_value;
        logic [ITEM_COUNT_W-1:0] item_count;
    } outcome_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [OPCODE_W-1:0]     opcode      = OP_START;
    logic [WORD_W-1:0]       entry_value = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic                    has_current;
    logic [WORD_W-1:0]       current_value;
    logic [ITEM_COUNT_W-1:0] item_count;

    // shadow copy of the store
    logic [WORD_W-1:0] seq_words [CAPACITY];
    int                seq_count  = 0;
    int                seq_cursor = 0;

    outcome_t expected_results [$];
    outcome_t oldest_result;
    int       error_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       quiet_cycles  = 0;
    bit       growing       = 1'b1;

    cursor_sequence_buffer_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .has_current   (has_current),
        .current_value (current_value),
        .item_count    (item_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit on_item();
        return seq_cursor < seq_count;
    endfunction

    function automatic outcome_t apply_op(input logic [OPCODE_W-1:0] op,
                                          input logic [WORD_W-1:0] word);
        outcome_t res;
        int       i;
        res.status = ST_DONE;
        case (op) inside
            OP_START:
                seq_cursor = 0;
            OP_ADVANCE:
            begin
                if (on_item())
                    seq_cursor++;
                else
                    res.status = ST_NO_CURRENT;
            end
            OP_INSERT, OP_ATTACH:
            begin
                if (seq_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    if (op == OP_INSERT)
                    begin
                        if (!on_item())
                            seq_cursor = 0;
                    end
                    else if (on_item())
                        seq_cursor++;
                    else
                        seq_cursor = seq_count;
                    for (i = seq_count; i > seq_cursor; i--)
                        seq_words[i] = seq_words[i-1];
                    seq_words[seq_cursor] = word;
                    seq_count++;
                end
            end
            OP_REMOVE:
            begin
                if (!on_item())
                    res.status = ST_NO_CURRENT;
                else
                begin
                    for (i = seq_cursor; i + 1 < seq_count; i++)
                        seq_words[i] = seq_words[i+1];
                    seq_count--;
                end
            end
            default:
            begin
            end
        endcase
        res.has_current   = on_item();
        res.current_value = on_item() ? seq_words[seq_cursor] : '0;
        res.item_count    = seq_count[ITEM_COUNT_W-1:0];
        return res;
    endfunction

    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        entry_value <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(apply_op(op, word));
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_store();
        send_word(OP_START, random_word());
        send_word(OP_ADVANCE, random_word());
        send_word(OP_REMOVE, random_word());
        send_word(OP_RSVD_0, random_word());
        send_word(OP_RSVD_1, '1);
        send_word(OP_RSVD_2, random_word());
    endtask

    task automatic test_insert_attach_order();
        send_word(OP_INSERT, '0);
        send_word(OP_ATTACH, '1);
        send_word(OP_ADVANCE, random_word());
        send_word(OP_ATTACH, 64'hA5A5_A5A5_A5A5_A5A5);
        send_word(OP_ADVANCE, random_word());
        send_word(OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A);
        send_word(OP_START, random_word());
        send_word(OP_ADVANCE, random_word());
        send_word(OP_INSERT, 64'h0123_4567_89AB_CDEF);
        send_word(OP_REMOVE, random_word());
    endtask

    task automatic test_remove_last();
        send_word(OP_START, random_word());
        while (seq_cursor + 1 < seq_count)
            send_word(OP_ADVANCE, random_word());
        send_word(OP_REMOVE, random_word());
        send_word(OP_START, random_word());
        send_word(OP_REMOVE, random_word());
    endtask

    // growth and shrink bias so the store swings between empty and full
    task automatic test_random_traffic(input int n_words, input int snd_pct, input int rcv_pct);
        int                  n;
        int                  r;
        logic [OPCODE_W-1:0] op;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (n = 0; n < n_words; n++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                op = OPCODE_W'($urandom_range(OP_RSVD_2, OP_RSVD_0));
            else if (r < (growing ? 15 : 20))
                op = OP_START;
            else if (r < (growing ? 30 : 35))
                op = OP_ADVANCE;
            else if (r < (growing ? 60 : 45))
                op = OP_INSERT;
            else if (r < (growing ? 90 : 55))
                op = OP_ATTACH;
            else
                op = OP_REMOVE;
            send_word(op, random_word());
            if (seq_count >= CAPACITY)
                growing = 1'b0;
            else if (seq_count == 0)
                growing = 1'b1;
        end
    endtask

    task automatic test_pause_until_drained();
        int n;
        for (n = 0; n < 3; n++)
            send_word(OP_ATTACH, random_word());
        wait_drained();
        for (n = 0; n < 3; n++)
            send_word(OP_INSERT, random_word());
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest_result.status, status);
                        error_count++;
                    end
                    if (has_current !== oldest_result.has_current)
                    begin
                        $error("has_current: expected %0d, got %0d",
                               oldest_result.has_current, has_current);
                        error_count++;
                    end
                    if (current_value !== oldest_result.current_value)
                    begin
                        $error("current_value: expected %h, got %h",
                               oldest_result.current_value, current_value);
                        error_count++;
                    end
                    if (item_count !== oldest_result.item_count)
                    begin
                        $error("item_count: expected %0d, got %0d",
                               oldest_result.item_count, item_count);
                        error_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 68;
        test_empty_store();
        test_insert_attach_order();
        test_remove_last();
        test_random_traffic(500, 35, 68);
        test_pause_until_drained();
        test_random_traffic(500, 68, 35);
        test_random_traffic(500, 0, 0);
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
